[rtl/core/ssobm_pkg.sv]
// ============================================================================
// Swept-sine oscillator bank package
// Shared types, widths, codes and the sine table builder for the oscillator
// bank and mixer.
// ============================================================================
package ssobm_pkg;

  // Bank size and table size.
  localparam int OSCILLATORS      = 32;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int COUNTER_WIDTH    = 24;

  localparam int OSC_IDX_W  = (OSCILLATORS > 1) ? $clog2(OSCILLATORS) : 1;
  localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_W     = 16;

  // Field and register widths.
  localparam int FREQ_IN_W = 24;
  localparam int IDX_IN_W  = 5;
  localparam int STEP_W    = 39;
  localparam int SWEEP_W   = 32;
  localparam int COUNT_W   = 24;
  localparam int CFG_W     = 39;
  localparam int CFG_IDX_W = 2;
  localparam int MIX_W     = 18;
  localparam int PHASE_W   = 32;

  // Sweep progress is (counter * sweep) >> 24.
  localparam int PROG_W = COUNTER_WIDTH + SWEEP_W - 24;

  // Only the low 56 bits of the frequency reach bits 55:24 of the increment.
  localparam int FREQ_W       = 56;
  localparam int FREQ_PIECE_W = FREQ_W / 2;

  // Shared multiplier: signed A by signed B, registered product.
  localparam int MUL_A_W = (PROG_W + 1 > STEP_W + 1) ? PROG_W + 1 : STEP_W + 1;
  localparam int MUL_B_W = FREQ_PIECE_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Running sum of sine values over the bank.
  localparam int SUM_W = SINE_W + OSC_IDX_W + 1;

  localparam int CNT_CMP_W = (COUNTER_WIDTH + 1 > COUNT_W) ? COUNTER_WIDTH + 1 : COUNT_W;

  // Mixer gain 0.06 in Q16, rounding constant and output limits.
  localparam int MIX_GAIN  = 3932;
  localparam int MIX_ROUND = 16384;
  localparam int MIX_SHIFT = 15;
  localparam int OUT_MAX   = 131071;
  localparam int OUT_MIN   = -131072;

  // Reset values of the configuration registers.
  localparam logic [STEP_W-1:0]  STEP_RESET  = 39'd6382652533;
  localparam logic [SWEEP_W-1:0] SWEEP_RESET = 32'd415537;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 24'd44100;

  // Odd Taylor coefficients of sin(pi/2 * u) in Q30.
  localparam longint POLY_Q30_0 = 64'sd1686629713;
  localparam longint POLY_Q30_1 = 64'sd693598668;
  localparam longint POLY_Q30_2 = 64'sd85569306;
  localparam longint POLY_Q30_3 = 64'sd5026995;
  localparam longint POLY_Q30_4 = 64'sd172273;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_SWEEP      = 2'd1,
    CFG_COUNT      = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROG_LO,
    ST_PROG_HI,
    ST_PROG_SUM,
    ST_DELTA,
    ST_FREQ,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_PHASE,
    ST_INDEX,
    ST_SINE,
    ST_SUM,
    ST_MIX,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e                  operation;
    logic [IDX_IN_W-1:0]  oscillator_index;
    logic [FREQ_IN_W-1:0] start_frequency;
    logic [FREQ_IN_W-1:0] end_frequency;
  } in_item_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mixed_sample;
    logic                    last_sample;
  } out_item_t;

  typedef struct packed {
    logic load_en;
    logic phase_we;
    logic clear_all;
  } store_ctrl_t;

  typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

  // sin(pi/2 * u) for u in Q30 over [0, 2^30], result in Q15.
  function automatic longint ssobm_quarter_sine(longint u);
    longint u2;
    longint acc;
    longint r;
    u2  = (u * u) >>> 30;
    acc = POLY_Q30_4;
    acc = POLY_Q30_3 - ((acc * u2) >>> 30);
    acc = POLY_Q30_2 - ((acc * u2) >>> 30);
    acc = POLY_Q30_1 - ((acc * u2) >>> 30);
    acc = POLY_Q30_0 - ((acc * u2) >>> 30);
    r   = (acc * u) >>> 30;
    r   = (r + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < 64'sd0) r = 64'sd0;
    return r;
  endfunction

  // Full-wave table folded from the quarter wave; evaluated at elaboration.
  function automatic sine_rom_t ssobm_build_sine_rom();
    sine_rom_t rom;
    longint    q4;
    longint    quad;
    longint    rem;
    longint    x;
    longint    u;
    longint    s;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      q4   = longint'(k) * 4;
      quad = q4 / SINE_TABLE_DEPTH;
      rem  = q4 % SINE_TABLE_DEPTH;
      x    = quad[0] ? (SINE_TABLE_DEPTH - rem) : rem;
      u    = (x <<< 30) / SINE_TABLE_DEPTH;
      s    = ssobm_quarter_sine(u);
      rom[k] = quad[1] ? SINE_W'(-s) : SINE_W'(s);
    end
    return rom;
  endfunction

endpackage

[rtl/core/ssobm_mul.sv]
// ============================================================================
// Shared multiplier
// Signed multiplier with a registered product, reused for every product of
// the oscillator bank.
// ============================================================================
module ssobm_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [ssobm_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [ssobm_pkg::MUL_B_W-1:0] b_i,
  output logic signed [ssobm_pkg::MUL_P_W-1:0] prod_o
);
  import ssobm_pkg::*;

  logic signed [MUL_P_W-1:0] prod_q;

  // The product holds while the unit is not issued.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

[rtl/core/ssobm_store.sv]
// ============================================================================
// Oscillator store
// Start frequency, end frequency and phase of every oscillator in the bank.
// ============================================================================
module ssobm_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ssobm_pkg::store_ctrl_t            ctrl_i,
  input  logic [ssobm_pkg::OSC_IDX_W-1:0]   wr_idx_i,
  input  logic [ssobm_pkg::OSC_IDX_W-1:0]   rd_idx_i,
  input  logic [ssobm_pkg::FREQ_IN_W-1:0]   start_freq_i,
  input  logic [ssobm_pkg::FREQ_IN_W-1:0]   end_freq_i,
  input  logic [ssobm_pkg::PHASE_W-1:0]     phase_i,
  output logic [ssobm_pkg::FREQ_IN_W-1:0]   start_freq_o,
  output logic [ssobm_pkg::FREQ_IN_W-1:0]   end_freq_o,
  output logic [ssobm_pkg::PHASE_W-1:0]     phase_o
);
  import ssobm_pkg::*;

  logic [FREQ_IN_W-1:0] start_q [OSCILLATORS];
  logic [FREQ_IN_W-1:0] end_q   [OSCILLATORS];
  logic [PHASE_W-1:0]   phase_q [OSCILLATORS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < OSCILLATORS; k++) begin
        start_q[k] <= '0;
        end_q[k]   <= '0;
      end
    end else if (ctrl_i.load_en) begin
      start_q[wr_idx_i] <= start_freq_i;
      end_q[wr_idx_i]   <= end_freq_i;
    end
  end

  // A run end clears every phase at once; a load clears its own.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < OSCILLATORS; k++) begin
        phase_q[k] <= '0;
      end
    end else if (ctrl_i.clear_all) begin
      for (int k = 0; k < OSCILLATORS; k++) begin
        phase_q[k] <= '0;
      end
    end else begin
      if (ctrl_i.phase_we) begin
        phase_q[rd_idx_i] <= phase_i;
      end
      if (ctrl_i.load_en) begin
        phase_q[wr_idx_i] <= '0;
      end
    end
  end

  assign start_freq_o = start_q[rd_idx_i];
  assign end_freq_o   = end_q[rd_idx_i];
  assign phase_o      = phase_q[rd_idx_i];

endmodule

[rtl/core/ssobm_sine_rom.sv]
// ============================================================================
// Sine table
// Full-wave Q1.15 sine table with a registered read port.
// ============================================================================
module ssobm_sine_rom (
  input  logic                                clk_i,
  input  logic [ssobm_pkg::SINE_IDX_W-1:0]    addr_i,
  output logic signed [ssobm_pkg::SINE_W-1:0] data_o
);
  import ssobm_pkg::*;

  localparam sine_rom_t SineRom = ssobm_build_sine_rom();

  logic signed [SINE_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= SineRom[addr_i];
  end

  assign data_o = data_q;

endmodule

[rtl/core/swept_sine_oscillator_bank_mixer_unit.sv]
// ============================================================================
// Swept-sine oscillator bank mixer
// A bank of linear-chirp sine oscillators whose sines are summed, scaled and
// delivered as one mixed sample per tick transaction.
// ============================================================================
//
//   Channel   Signals                                Direction  Width
//   --------  -------------------------------------  ---------  -----------
//   input     in_valid_i, in_ready_o, in_data_i      in         in_item_t
//   output    out_valid_o, out_ready_i, out_data_o   out        out_item_t
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i       in         2 + 39 bits
//
// A load transaction is written at acceptance and gives no result. A tick
// transaction is paced by the single shared multiplier, which every
// oscillator visits three times in a fixed seven-step sequence.
// Reset clears the sequencer, the sample counter and all oscillator stores
// at once and loads the configuration reset values; there is no clearing pass.
// A finished sample waits in the output register; the sequencer stalls only
// when the next sample is ready while the previous one is still not taken.
//
module swept_sine_oscillator_bank_mixer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ssobm_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ssobm_pkg::out_item_t                out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ssobm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ssobm_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import ssobm_pkg::*;

  localparam logic signed [MUL_P_W-1:0] MixMax = MUL_P_W'(OUT_MAX);
  localparam logic signed [MUL_P_W-1:0] MixMin = MUL_P_W'(OUT_MIN);

  // Sequencer state.
  state_e state_q, state_d;

  // Configuration registers.
  logic [STEP_W-1:0]  step_q;
  logic [SWEEP_W-1:0] sweep_q;
  logic [COUNT_W-1:0] count_q;

  // Run control.
  logic [COUNTER_WIDTH-1:0] counter_q;
  logic [OSC_IDX_W-1:0]     osc_q;
  logic                     osc_last;

  // Datapath registers.
  logic [PROG_W-1:0]          prog_q;
  logic [FREQ_W-1:0]          freq_q;
  logic signed [MUL_P_W-1:0]  pl_q;
  logic [SINE_IDX_W-1:0]      tidx_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic                       sine_vld_q;

  // Output register.
  logic      out_valid_q;
  out_item_t out_data_q;

  // Shared multiplier connections.
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  // Store connections.
  store_ctrl_t          store_ctrl;
  logic [OSC_IDX_W-1:0] load_idx;
  logic                 load_ok;
  logic [FREQ_IN_W-1:0] start_rd;
  logic [FREQ_IN_W-1:0] end_rd;
  logic [PHASE_W-1:0]   phase_rd;
  logic [PHASE_W-1:0]   phase_new;

  logic signed [SINE_W-1:0] sine;

  // Arithmetic between the registers.
  logic [COUNTER_WIDTH+31:0]  prog_full;
  logic signed [FREQ_IN_W:0]  delta;
  logic signed [47:0]         offset;
  logic [FREQ_W-1:0]          freq_d;
  logic [PHASE_W-1:0]         inc;
  logic [63:0]                tidx_prod;
  logic signed [MUL_P_W-1:0]  mix_round;
  logic signed [MUL_P_W-1:0]  mix_shift;
  logic signed [MIX_W-1:0]    mix_sat;
  logic [COUNTER_WIDTH:0]     cnt_next;
  logic                       last_d;
  logic                       out_load;

  assign in_ready_o = (state_q == ST_IDLE);

  // A load transaction writes its oscillator at acceptance; an index past
  // the bank is dropped.
  assign load_ok  = 32'(in_data_i.oscillator_index) < 32'(OSCILLATORS);
  assign load_idx = OSC_IDX_W'(in_data_i.oscillator_index);

  assign osc_last = (osc_q == OSC_IDX_W'(OSCILLATORS - 1));

  // Sweep progress: the counter times the two 16-bit halves of the sweep
  // rate, combined and shifted down by 24.
  assign prog_full = pl_q[COUNTER_WIDTH+31:0] + {prod[COUNTER_WIDTH+15:0], 16'b0};

  // The frequency offset is the product shifted right by 16, taken modulo
  // 2^64 as a signed value. Only the low 56 bits of the frequency matter.
  assign delta  = $signed({1'b0, end_rd}) - $signed({1'b0, start_rd});
  assign offset = prod[63:16];
  assign freq_d = FREQ_W'(start_rd) + FREQ_W'(offset);

  // Increment bits 55:24 of step * freq, built from the low and high halves
  // of the frequency. The high product only lands above bit 27.
  assign inc       = pl_q[55:24] + {prod[FREQ_PIECE_W-1:0], 4'b0000};
  assign phase_new = phase_rd + inc;

  // Table index is the phase scaled to the table depth.
  assign tidx_prod = {32'b0, phase_rd} * 64'(SINE_TABLE_DEPTH);

  // Mixer output: round the Q31 sum down to Q16 and saturate.
  assign mix_round = prod + MUL_P_W'(MIX_ROUND);
  assign mix_shift = mix_round >>> MIX_SHIFT;

  always_comb begin
    if (mix_shift > MixMax) begin
      mix_sat = MIX_W'(MixMax);
    end else if (mix_shift < MixMin) begin
      mix_sat = MIX_W'(MixMin);
    end else begin
      mix_sat = MIX_W'(mix_shift);
    end
  end

  // Run end: the sample whose successor count reaches the run length is last.
  assign cnt_next = {1'b0, counter_q} + 1'b1;
  assign last_d   = CNT_CMP_W'(cnt_next) >= CNT_CMP_W'(count_q);

  // --------------------------------------------------------------------------
  // Sequencer: next state, multiplier operands and store controls.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    store_ctrl = '0;
    out_load   = 1'b0;

    store_ctrl.load_en = in_valid_i && in_ready_o &&
                         (in_data_i.operation == OP_LOAD) && load_ok;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_data_i.operation == OP_TICK)) begin
          state_d = ST_PROG_LO;
        end
      end
      ST_PROG_LO: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(counter_q);
        mul_b   = MUL_B_W'(sweep_q[15:0]);
        state_d = ST_PROG_HI;
      end
      ST_PROG_HI: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(counter_q);
        mul_b   = MUL_B_W'(sweep_q[31:16]);
        state_d = ST_PROG_SUM;
      end
      ST_PROG_SUM: begin
        state_d = ST_DELTA;
      end
      ST_DELTA: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(prog_q);
        mul_b   = MUL_B_W'(delta);
        state_d = ST_FREQ;
      end
      ST_FREQ: begin
        state_d = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(step_q);
        mul_b   = MUL_B_W'(freq_q[FREQ_PIECE_W-1:0]);
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(step_q);
        mul_b   = MUL_B_W'(freq_q[FREQ_W-1:FREQ_PIECE_W]);
        state_d = ST_PHASE;
      end
      ST_PHASE: begin
        store_ctrl.phase_we = 1'b1;
        state_d             = ST_INDEX;
      end
      ST_INDEX: begin
        state_d = ST_SINE;
      end
      ST_SINE: begin
        state_d = osc_last ? ST_SUM : ST_DELTA;
      end
      ST_SUM: begin
        state_d = ST_MIX;
      end
      ST_MIX: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(sum_q);
        mul_b   = MUL_B_W'(MIX_GAIN);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Hold here while the previous sample is still waiting.
        if (!out_valid_q || out_ready_i) begin
          out_load             = 1'b1;
          store_ctrl.clear_all = last_d;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes; an index past the register list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_RESET;
      sweep_q <= SWEEP_RESET;
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_PHASE_STEP: step_q  <= cfg_wdata_i[STEP_W-1:0];
        CFG_SWEEP:      sweep_q <= cfg_wdata_i[SWEEP_W-1:0];
        CFG_COUNT:      count_q <= cfg_wdata_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sample counter and oscillator pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q  <= '0;
      osc_q      <= '0;
      sine_vld_q <= 1'b0;
    end else begin
      sine_vld_q <= (state_q == ST_SINE);
      if (state_q == ST_SINE) begin
        osc_q <= osc_last ? '0 : osc_q + 1'b1;
      end
      if (out_load) begin
        counter_q <= last_d ? '0 : cnt_next[COUNTER_WIDTH-1:0];
      end
    end
  end

  // Datapath registers; they carry no control and need no reset.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_PROG_HI) || (state_q == ST_MUL_HI)) begin
      pl_q <= prod;
    end
    if (state_q == ST_PROG_SUM) begin
      prog_q <= prog_full[COUNTER_WIDTH+31:24];
    end
    if (state_q == ST_FREQ) begin
      freq_q <= freq_d;
    end
    if (state_q == ST_INDEX) begin
      tidx_q <= tidx_prod[32 +: SINE_IDX_W];
    end
    // Each sine joins the running sum once the table's registered read is valid.
    if (state_q == ST_PROG_LO) begin
      sum_q <= '0;
    end else if (sine_vld_q) begin
      sum_q <= sum_q + SUM_W'(sine);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.mixed_sample <= mix_sat;
      out_data_q.last_sample  <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Submodules.
  // --------------------------------------------------------------------------
  ssobm_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ssobm_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (store_ctrl),
    .wr_idx_i     (load_idx),
    .rd_idx_i     (osc_q),
    .start_freq_i (in_data_i.start_frequency),
    .end_freq_i   (in_data_i.end_frequency),
    .phase_i      (phase_new),
    .start_freq_o (start_rd),
    .end_freq_o   (end_rd),
    .phase_o      (phase_rd)
  );

  ssobm_sine_rom u_sine_rom (
    .clk_i  (clk_i),
    .addr_i (tidx_q),
    .data_o (sine)
  );

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // A new result only appears when the sequencer finishes a sample.
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("output became valid outside the final sequencer step");

  // An accepted tick starts the sweep progress computation.
  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.operation == OP_TICK)
      |=> state_q == ST_PROG_LO)
    else $error("accepted tick did not start the sequencer");

  // The last sample of a run leaves the counter and the pointer at zero.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_d) |=> (counter_q == '0) && (osc_q == '0))
    else $error("run end did not clear the sample counter");

  // Every sample visits the whole bank before mixing.
  a_bank_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> $past(osc_last))
    else $error("mix started before the last oscillator");

endmodule

[verif/ssobm_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// Oscillator bank mixer checker
// Watches the input, output and register-write ports of the oscillator bank,
// keeps its own copy of the bank state and compares every mixed sample.
// ============================================================================
module ssobm_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  ssobm_pkg::in_item_t             in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  ssobm_pkg::out_item_t            out_data_i,
  input  logic                            cfg_we_i,
  input  logic [ssobm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ssobm_pkg::CFG_W-1:0]     cfg_wdata_i,
  output int                              mismatches_o,
  output int                              pending_o,
  output int                              samples_o,
  output int                              run_ends_o
);
  import ssobm_pkg::*;

  localparam int MAX_REPORTS = 40;
  // The phase increment is taken from bits 55:24 of frequency times step.
  localparam int INC_LSB     = 24;

  logic [STEP_W-1:0]        step_reg;
  logic [SWEEP_W-1:0]       sweep_reg;
  logic [COUNT_W-1:0]       count_reg;
  logic [PHASE_W-1:0]       osc_phase [OSCILLATORS];
  logic [FREQ_IN_W-1:0]     osc_start [OSCILLATORS];
  logic [FREQ_IN_W-1:0]     osc_stop  [OSCILLATORS];
  logic [COUNTER_WIDTH-1:0] run_pos;
  int                       wave_lut  [SINE_TABLE_DEPTH];
  out_item_t                sample_q  [$];
  out_item_t                predicted;
  out_item_t                oldest;

  // Full-wave Q1.15 table, folded from a quarter-wave odd polynomial in Q30.
  initial begin
    longint q4;
    longint quad;
    longint rem;
    longint x;
    longint u;
    longint usq;
    longint h;
    longint r;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      q4   = longint'(k) * 4;
      quad = q4 / SINE_TABLE_DEPTH;
      rem  = q4 % SINE_TABLE_DEPTH;
      x    = quad[0] ? (SINE_TABLE_DEPTH - rem) : rem;
      u    = (x <<< 30) / SINE_TABLE_DEPTH;
      usq  = (u * u) >>> 30;
      h    = POLY_Q30_4;
      h    = POLY_Q30_3 - ((h * usq) >>> 30);
      h    = POLY_Q30_2 - ((h * usq) >>> 30);
      h    = POLY_Q30_1 - ((h * usq) >>> 30);
      h    = POLY_Q30_0 - ((h * usq) >>> 30);
      r    = (h * u) >>> 30;
      r    = (r + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < 0) r = 0;
      wave_lut[k] = quad[1] ? -r : r;
    end
  end

  task automatic report_mismatch(string what);
    mismatches_o++;
    if (mismatches_o <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // One tick: sweep every oscillator, advance its phase, mix the sines and
  // step the run position.
  task automatic advance_bank(output out_item_t res);
    logic [63:0]        prog;
    logic [63:0]        fr;
    logic [63:0]        prod;
    logic [PHASE_W-1:0] nph;
    longint             spread;
    longint             offs;
    longint             accum;
    longint             level;
    logic               fin;
    accum = 0;
    prog  = (64'(run_pos) * 64'(sweep_reg)) >> 24;
    for (int k = 0; k < OSCILLATORS; k++) begin
      spread = longint'(osc_stop[k]) - longint'(osc_start[k]);
      offs   = (spread * longint'(prog)) >>> 16;
      fr     = 64'(longint'(osc_start[k]) + offs);
      prod   = fr * 64'(step_reg);
      nph    = osc_phase[k] + prod[INC_LSB +: PHASE_W];
      osc_phase[k] = nph;
      accum += longint'(wave_lut[nph[PHASE_W-1 -: SINE_IDX_W]]) * MIX_GAIN;
    end
    level = (accum + MIX_ROUND) >>> MIX_SHIFT;
    if (level > OUT_MAX) level = OUT_MAX;
    if (level < OUT_MIN) level = OUT_MIN;
    fin = (64'(run_pos) + 64'd1) >= 64'(count_reg);
    if (fin) begin
      run_pos = '0;
      for (int k = 0; k < OSCILLATORS; k++) osc_phase[k] = '0;
    end else begin
      run_pos = run_pos + 1'b1;
    end
    res.mixed_sample = MIX_W'(level);
    res.last_sample  = fin;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_reg  = STEP_RESET;
      sweep_reg = SWEEP_RESET;
      count_reg = COUNT_RESET;
      for (int k = 0; k < OSCILLATORS; k++) begin
        osc_phase[k] = '0;
        osc_start[k] = '0;
        osc_stop[k]  = '0;
      end
      run_pos = '0;
      sample_q.delete();
      pending_o    = 0;
      mismatches_o = 0;
      samples_o    = 0;
      run_ends_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PHASE_STEP: step_reg  = cfg_wdata_i[STEP_W-1:0];
          CFG_SWEEP:      sweep_reg = cfg_wdata_i[SWEEP_W-1:0];
          CFG_COUNT:      count_reg = cfg_wdata_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      // Results leave before this edge's input is taken, so they always
      // belong to an older tick.
      if (out_valid_i && out_ready_i) begin
        samples_o++;
        if (out_data_i.last_sample) run_ends_o++;
        if (sample_q.size() == 0) begin
          report_mismatch("result arrived with no prediction waiting");
        end else begin
          oldest = sample_q.pop_front();
          if (out_data_i.mixed_sample !== oldest.mixed_sample)
            report_mismatch($sformatf("mixed_sample got %0d, predicted %0d",
                                      out_data_i.mixed_sample, oldest.mixed_sample));
          if (out_data_i.last_sample !== oldest.last_sample)
            report_mismatch($sformatf("last_sample got %0b, predicted %0b",
                                      out_data_i.last_sample, oldest.last_sample));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.operation == OP_TICK) begin
          advance_bank(predicted);
          sample_q.push_back(predicted);
        end else if (int'(in_data_i.oscillator_index) < OSCILLATORS) begin
          // A load outside the bank is dropped.
          osc_start[in_data_i.oscillator_index] = in_data_i.start_frequency;
          osc_stop[in_data_i.oscillator_index]  = in_data_i.end_frequency;
          osc_phase[in_data_i.oscillator_index] = '0;
        end
      end
      pending_o = sample_q.size();
    end
  end

endmodule

[verif/tb_swept_sine_oscillator_bank_mixer_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// Oscillator bank mixer testbench
// Drives load and tick transactions into the swept-sine oscillator bank under
// a series of register settings, with random gaps and stalls on both
// channels; a separate checker predicts and compares every mixed sample.
// ============================================================================
module tb_swept_sine_oscillator_bank_mixer_unit;
  import ssobm_pkg::*;

  localparam int     RESET_CYCLES  = 5;
  // This settle time covers a whole tick computation with margin.
  localparam int     SETTLE_CYCLES = 300;
  // Long output hold-off, enough to fill the block.
  localparam int     HOLD_CYCLES   = 2500;
  // Worst case is roughly 1100 ticks, each behind the longest sender gap and
  // receiver stall, plus the hold-off and settle pauses; the limit is a few
  // times that.
  localparam longint CYCLE_LIMIT   = 5_000_000;
  localparam int     RANDOM_PHASES = 10;
  // The phase in which the sweep runs far past its end frequency.
  localparam int     EXTRAP_PHASE  = 4;
  localparam int     PHASE_ITEMS   = 85;
  localparam int     EXTRAP_ITEMS  = 330;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  int     mismatches;
  int     pending;
  int     samples;
  int     run_ends;
  bit     sender_gaps_on     = 1'b1;
  bit     receiver_stalls_on = 1'b1;
  bit     hold_req           = 1'b0;
  int     holds_done         = 0;
  int     loads_sent         = 0;
  int     ticks_sent         = 0;
  int     settings_applied   = 0;
  longint cycles             = 0;

  swept_sine_oscillator_bank_mixer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  ssobm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .samples_o    (samples),
    .run_ends_o   (run_ends)
  );

  // 4 ns clock period.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Idle lengths: usually none or a few cycles, now and then long enough to
  // cover a whole tick computation.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 30);
    return $urandom_range(60, 400);
  endfunction

  // Frequencies lean on the extremes, since those stress the sweep sign and
  // the phase wrap the most.
  function automatic logic [FREQ_IN_W-1:0] pick_freq();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return FREQ_IN_W'($urandom);
  endfunction

  // Every field is random; the operation is a tick with the given percentage.
  // Ticks carry random index and frequencies too, which the block must ignore.
  function automatic in_item_t random_item(int tick_pct);
    in_item_t it;
    it.oscillator_index = IDX_IN_W'($urandom);
    it.start_frequency  = pick_freq();
    it.end_frequency    = pick_freq();
    it.operation        = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_LOAD;
    return it;
  endfunction

  function automatic in_item_t load_item(int idx, logic [FREQ_IN_W-1:0] f0,
                                         logic [FREQ_IN_W-1:0] f1);
    in_item_t it;
    it.operation        = OP_LOAD;
    it.oscillator_index = IDX_IN_W'(idx);
    it.start_frequency  = f0;
    it.end_frequency    = f1;
    return it;
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return STEP_W'(1);
      2:       return '1;
      3:       return STEP_RESET;
      default: return STEP_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [SWEEP_W-1:0] pick_sweep();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return SWEEP_RESET;
      default: return SWEEP_W'($urandom);
    endcase
  endfunction

  // Short runs dominate so that run ends and phase clears show up often.
  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return COUNT_W'(1);
      2:       return COUNT_W'($urandom_range(2, 12));
      3:       return COUNT_W'($urandom_range(20, 200));
      default: return '1;
    endcase
  endfunction

  // Offers one transaction, called and returning at a falling edge. With no
  // gap, valid simply stays high into the next transaction.
  task automatic send(in_item_t it);
    int gap;
    gap = sender_gaps_on ? idle_length() : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (it.operation == OP_TICK) ticks_sent++;
    else loads_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
  endtask

  // Registers only change with the bank idle: every predicted sample must
  // have been taken, and the settle time lets a trailing load finish.
  task automatic reconfigure(logic [STEP_W-1:0] step, logic [SWEEP_W-1:0] sweep,
                             logic [COUNT_W-1:0] count);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg(CFG_PHASE_STEP, CFG_W'(step));
    write_reg(CFG_SWEEP, CFG_W'(sweep));
    write_reg(CFG_COUNT, CFG_W'(count));
    cfg_we_i = 1'b0;
    settings_applied++;
  endtask

  // Receiver: random stalls, plus one long hold-off on request. The hold-off
  // is counted here so the sender keeps offering ticks meanwhile.
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if (receiver_stalls_on && $urandom_range(0, 99) < 12) begin
        out_ready_i = 1'b0;
        stall_left  = idle_length();
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Run stopped by the watchdog after %0d cycles.", cycles);
    $display("FAILURE");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int n_items;
    int tick_pct;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_PHASE_STEP;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, at the reset register values. A tick on an empty bank
    // must give silence.
    send(random_item(100));
    // Full-range sweeps up and down, a flat top tone, and a mixed pattern,
    // covering the first and last oscillator.
    send(load_item(0, '0, '1));
    send(load_item(OSCILLATORS - 1, '1, '0));
    send(load_item(7, '1, '1));
    send(load_item(16, 24'h5A5A5A, 24'hA5A5A5));
    repeat (4) send(random_item(100));
    // Reloading an oscillator in the middle of a run restarts its phase.
    send(load_item(0, 24'h123456, 24'h000100));
    repeat (2) send(random_item(100));

    // Zero phase step: phases hold, so the mix repeats itself.
    reconfigure('0, SWEEP_RESET, COUNT_RESET);
    repeat (3) send(random_item(100));

    // Zero sample count with the largest step and sweep: every tick ends a run.
    reconfigure('1, '1, '0);
    repeat (3) send(random_item(100));

    // One-sample runs with the smallest step and no sweep.
    reconfigure(STEP_W'(1), '0, COUNT_W'(1));
    repeat (2) send(random_item(100));

    // Random part: each phase picks new register values and its own idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == EXTRAP_PHASE) begin
        // With the largest sweep the fraction passes one after 256 samples,
        // so downward sweeps go below zero and the phases run backwards.
        reconfigure(STEP_RESET, '1, '1);
        for (int k = 0; k < OSCILLATORS; k += 4)
          send(load_item(k, '1 - FREQ_IN_W'($urandom_range(0, 4095)),
                         FREQ_IN_W'($urandom_range(0, 255))));
        n_items  = EXTRAP_ITEMS;
        tick_pct = 90;
      end else begin
        reconfigure(pick_step(), pick_sweep(), pick_count());
        n_items  = PHASE_ITEMS;
        tick_pct = 75;
      end
      // Every third phase runs with no idling at all on either side.
      sender_gaps_on     = (p % 3 != 1);
      receiver_stalls_on = (p % 3 != 1);
      // The first random phase holds the output off long enough for the
      // block to fill up and stall its input.
      if (p == 0) hold_req = 1'b1;
      for (int k = 0; k < n_items; k++) send(random_item(tick_pct));
    end

    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Sent %0d loads and %0d ticks under %0d register settings, %0d long hold-off(s).",
             loads_sent, ticks_sent, settings_applied + 1, holds_done);
    $display("Compared %0d mixed samples, %0d of them closing a run; %0d mismatches.",
             samples, run_ends, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
